### src/l2s_pkg.sv
// l2s_pkg: widths, register codes and the configuration struct of the
// linear index to subscripts unit. No dependencies; the design modules import it.
package l2s_pkg;

  localparam int unsigned IDX_W         = 32;  // linear index
  localparam int unsigned SUB_W         = 16;  // one subscript
  localparam int unsigned SIZE_W        = 16;  // one dimension extent
  localparam int unsigned DCNT_W        = 3;   // dimension count register
  localparam int unsigned NUM_SIZE_REGS = 4;   // extent registers on the bus
  localparam int unsigned NUM_SUBS      = 4;   // subscript fields per word
  localparam int unsigned STRIDE_W      = 48;  // product of up to three extents
  localparam int unsigned PROD_W        = 64;  // product of up to four extents
  localparam int unsigned PADDR_W       = 5;
  localparam int unsigned PDATA_W       = 32;

  // register index, byte address is four times this
  typedef enum logic [2:0] {
    REG_DIM_COUNT = 3'd0,
    REG_SIZE_DIM0 = 3'd1,
    REG_SIZE_DIM1 = 3'd2,
    REG_SIZE_DIM2 = 3'd3,
    REG_SIZE_DIM3 = 3'd4
  } l2s_reg_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [DCNT_W-1:0]                         dim_count;
    logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0]      size_dim;
  } l2s_cfg_t;

endpackage

### src/l2s_if.sv
// l2s_if: valid/ready channels of the unit, one for the index word and one
// for the subscript word. No dependencies.
interface l2s_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] linear_index;

  modport source (output valid, output linear_index, input ready);
  modport sink   (input valid, input linear_index, output ready);
endinterface

interface l2s_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] subscript0;
  logic [15:0] subscript1;
  logic [15:0] subscript2;
  logic [15:0] subscript3;
  logic        index_error;

  modport source (output valid, output subscript0, output subscript1,
                  output subscript2, output subscript3, output index_error,
                  input ready);
  modport sink   (input valid, input subscript0, input subscript1,
                  input subscript2, input subscript3, input index_error,
                  output ready);
endinterface

### src/linear_index_to_subscripts_unit.sv
// linear_index_to_subscripts_unit: column-major index to subscripts converter.
// Depends on l2s_pkg, l2s_if, l2s_apb_regs, l2s_ser_mul, l2s_ser_div.
//
//   port       dir  kind        word
//   in_ch_i    in   valid/ready linear_index (signed 32 bits)
//   out_ch_o   out  valid/ready subscript0..3 (16 bits each), index_error
//   psel..     in   APB         dim_count at 0x00, size_dim0..3 at 0x04..0x10
//
// One word at a time. With n dimensions in use a word takes one pass of the
// serial multiplier per extent, then one pass of the serial divider per
// subscript. A bad index skips the divider.
// A finished word sits in the output register, so the next index is taken
// while it waits; a full output register holds the next result back.
// Reset sets dim_count and all extents to 1; there is no clearing pass.
module linear_index_to_subscripts_unit #(
  parameter int unsigned MAX_DIMS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  l2s_in_if.sink                      in_ch_i,
  l2s_out_if.source                   out_ch_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [l2s_pkg::PADDR_W-1:0] paddr,
  input  logic [l2s_pkg::PDATA_W-1:0] pwdata,
  output logic [l2s_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import l2s_pkg::*;

  localparam int unsigned NumDims = (MAX_DIMS < NUM_SIZE_REGS) ? MAX_DIMS : NUM_SIZE_REGS;
  localparam int unsigned DimW    = (NumDims > 1) ? $clog2(NumDims) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e   state_q, state_d;
  l2s_cfg_t cfg;

  logic [IDX_W-1:0]                   idx_q, idx_d;
  logic [DimW-1:0]                    nl_q, nl_d, k_q, k_d, nl_cfg;
  logic [NumDims-1:0][STRIDE_W-1:0]   stride_q, stride_d;
  logic [NUM_SUBS-1:0][SUB_W-1:0]     sub_q, sub_d, out_sub_q;
  logic                               err_q, err_d, out_err_q;
  logic                               out_vld_q, out_vld_d, out_load;
  logic                               accept;

  logic                mul_start, mul_done;
  logic [STRIDE_W-1:0] mul_mcand;
  logic [SIZE_W-1:0]   mul_mplier;
  logic [PROD_W-1:0]   mul_prod;
  logic                div_start, div_done;
  logic [IDX_W-1:0]    div_dvd, div_rem;
  logic [STRIDE_W-1:0] div_dvs;
  logic [SUB_W-1:0]    div_quo;

  l2s_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  l2s_ser_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  l2s_ser_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // last dimension in use: count zero means one, clamp at the built size
  always_comb begin
    if (cfg.dim_count == '0) begin
      nl_cfg = '0;
    end else if (cfg.dim_count > DCNT_W'(NumDims)) begin
      nl_cfg = DimW'(NumDims - 1);
    end else begin
      nl_cfg = DimW'(cfg.dim_count - 1'b1);
    end
  end

  assign in_ch_i.ready = (state_q == S_IDLE);
  assign accept        = in_ch_i.valid & in_ch_i.ready;
  assign out_load      = (state_q == S_DONE) & (~out_vld_q | out_ch_o.ready);

  // sequencer: strides and element count first, then subscripts top down
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    nl_d       = nl_q;
    k_d        = k_q;
    stride_d   = stride_q;
    sub_d      = sub_q;
    err_d      = err_q;
    mul_start  = 1'b0;
    mul_mcand  = STRIDE_W'(1);
    mul_mplier = cfg.size_dim[0];
    div_start  = 1'b0;
    div_dvd    = idx_q;
    div_dvs    = stride_q[nl_q];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d       = in_ch_i.linear_index;
          nl_d        = nl_cfg;
          k_d         = '0;
          stride_d[0] = STRIDE_W'(1);
          sub_d       = '0;
          err_d       = 1'b0;
          mul_start   = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          if (k_q != nl_q) begin
            stride_d[k_q + 1'b1] = mul_prod[STRIDE_W-1:0];
            k_d        = k_q + 1'b1;
            mul_mcand  = mul_prod[STRIDE_W-1:0];
            mul_mplier = cfg.size_dim[k_q + 1'b1];
            mul_start  = 1'b1;
          end else if (idx_q[IDX_W-1] || (PROD_W'(idx_q) >= mul_prod)) begin
            // negative or past the element count
            err_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            k_d       = nl_q;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          sub_d[k_q] = div_quo;
          if (k_q == '0) begin
            state_d = S_DONE;
          end else begin
            k_d       = k_q - 1'b1;
            div_dvd   = div_rem;
            div_dvs   = stride_q[k_q - 1'b1];
            div_start = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_vld_d = out_vld_q & ~out_ch_o.ready;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      nl_q      <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      nl_q      <= nl_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    stride_q <= stride_d;
    sub_q    <= sub_d;
    err_q    <= err_d;
    if (out_load) begin
      out_sub_q <= sub_q;
      out_err_q <= err_q;
    end
  end

  assign out_ch_o.valid       = out_vld_q;
  assign out_ch_o.subscript0  = out_sub_q[0];
  assign out_ch_o.subscript1  = out_sub_q[1];
  assign out_ch_o.subscript2  = out_sub_q[2];
  assign out_ch_o.subscript3  = out_sub_q[3];
  assign out_ch_o.index_error = out_err_q;

endmodule

### src/l2s_apb_regs.sv
// l2s_apb_regs: APB register file holding the dimension count and extents.
// Depends on l2s_pkg.
module l2s_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [l2s_pkg::PADDR_W-1:0] paddr,
  input  logic [l2s_pkg::PDATA_W-1:0] pwdata,
  output logic [l2s_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output l2s_pkg::l2s_cfg_t           cfg_o
);
  import l2s_pkg::*;

  l2s_cfg_t cfg_q, cfg_d;
  l2s_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = l2s_reg_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DIM_COUNT: cfg_d.dim_count   = pwdata[DCNT_W-1:0];
        REG_SIZE_DIM0: cfg_d.size_dim[0] = pwdata[SIZE_W-1:0];
        REG_SIZE_DIM1: cfg_d.size_dim[1] = pwdata[SIZE_W-1:0];
        REG_SIZE_DIM2: cfg_d.size_dim[2] = pwdata[SIZE_W-1:0];
        REG_SIZE_DIM3: cfg_d.size_dim[3] = pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_count <= DCNT_W'(1);
      for (int i = 0; i < NUM_SIZE_REGS; i++) begin
        cfg_q.size_dim[i] <= SIZE_W'(1);
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DIM_COUNT: prdata = PDATA_W'(cfg_q.dim_count);
      REG_SIZE_DIM0: prdata = PDATA_W'(cfg_q.size_dim[0]);
      REG_SIZE_DIM1: prdata = PDATA_W'(cfg_q.size_dim[1]);
      REG_SIZE_DIM2: prdata = PDATA_W'(cfg_q.size_dim[2]);
      REG_SIZE_DIM3: prdata = PDATA_W'(cfg_q.size_dim[3]);
      default:       prdata = '0;
    endcase
  end

endmodule

### src/l2s_ser_mul.sv
// l2s_ser_mul: bit-serial shift-add multiplier, one extent bit per cycle.
// Depends on l2s_pkg.
module l2s_ser_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [l2s_pkg::STRIDE_W-1:0] mcand_i,
  input  logic [l2s_pkg::SIZE_W-1:0]   mplier_i,
  output logic                         done_o,
  output logic [l2s_pkg::PROD_W-1:0]   prod_o
);
  import l2s_pkg::*;

  localparam int unsigned CntW = $clog2(SIZE_W);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [STRIDE_W-1:0] mcand_q;
  logic [SIZE_W-1:0]   mplier_q;
  logic [PROD_W-1:0]   prod_q, prod_d;

  // shift partial product, add multiplicand on a set multiplier msb
  assign prod_d = {prod_q[PROD_W-2:0], 1'b0}
                + (mplier_q[SIZE_W-1] ? PROD_W'(mcand_q) : PROD_W'(0));

  assign done_o = done_q;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SIZE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      prod_q   <= '0;
    end else if (busy_q) begin
      mplier_q <= {mplier_q[SIZE_W-2:0], 1'b0};
      prod_q   <= prod_d;
    end
  end

endmodule

### src/l2s_ser_div.sv
// l2s_ser_div: restoring divider, one quotient bit per cycle. The quotient is
// known to fit a subscript. Depends on l2s_pkg.
module l2s_ser_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [l2s_pkg::IDX_W-1:0]    dvd_i,
  input  logic [l2s_pkg::STRIDE_W-1:0] dvs_i,
  output logic                         done_o,
  output logic [l2s_pkg::SUB_W-1:0]    quo_o,
  output logic [l2s_pkg::IDX_W-1:0]    rem_o
);
  import l2s_pkg::*;

  localparam int unsigned DW   = STRIDE_W + SUB_W - 1;
  localparam int unsigned CntW = $clog2(SUB_W);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DW-1:0]    dvs_q;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [SUB_W-1:0] quo_q;
  logic             ge;

  // trial subtract of the aligned divisor
  assign ge    = DW'(rem_q) >= dvs_q;
  assign rem_d = ge ? rem_q - dvs_q[IDX_W-1:0] : rem_q;

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SUB_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= {dvs_i, {(SUB_W-1){1'b0}}};
      rem_q <= dvd_i;
      quo_q <= '0;
    end else if (busy_q) begin
      dvs_q <= {1'b0, dvs_q[DW-1:1]};
      rem_q <= rem_d;
      quo_q <= {quo_q[SUB_W-2:0], ge};
    end
  end

endmodule
